@@ src/utn_pkg.sv @@
// Shared types, constants and helper functions for the UTF-8 token normalizer.
`timescale 1ns / 1ps

package utn_pkg;

	localparam int unsigned CNT_W      = 16;
	localparam int unsigned MAX_DATA   = 6;
	localparam int unsigned FIFO_DEPTH = 4;
	localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

	localparam logic [15:0] LIMIT_RESET = 16'd1024;

	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_Z = 8'h5A;
	localparam logic [7:0] CH_CASE_OFS = 8'h20;
	localparam logic [7:0] CH_DIGIT_0 = 8'h30;
	localparam logic [7:0] CH_DIGIT_9 = 8'h39;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_LOWER_Z = 8'h7A;
	localparam logic [7:0] CH_APOS    = 8'h27;
	localparam logic [7:0] CH_COMMA   = 8'h2C;
	localparam logic [7:0] CH_AMP     = 8'h26;
	localparam logic [7:0] CH_HASH    = 8'h23;
	localparam logic [7:0] CH_SEMI    = 8'h3B;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_TAB     = 8'h09;
	localparam logic [7:0] CH_NUL     = 8'h00;
	localparam logic [7:0] CH_LF      = 8'h0A;
	localparam logic [7:0] CH_VT      = 8'h0B;
	localparam logic [7:0] CH_CR      = 8'h0D;

	localparam logic [31:0] U_NBSP       = 32'h0000_C2A0;
	localparam logic [31:0] U_OGHAM      = 32'h00E1_9A80;
	localparam logic [31:0] U_NNBSP      = 32'h00E2_80AF;
	localparam logic [31:0] U_MMSP       = 32'h00E2_819F;
	localparam logic [31:0] U_IDEO       = 32'h00E3_8080;
	localparam logic [31:0] U_RANGE_LO   = 32'h00E2_8080;
	localparam logic [31:0] U_RANGE_HI   = 32'h00E2_808B;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0]  out_byte;
		logic        end_marker;
		logic [15:0] out_count;
		logic        bad_input;
		logic        last_of_run;
	} out_item_t;

	// Everything one input byte asks of the back end.
	typedef struct packed {
		logic [MAX_DATA-1:0][7:0] data;
		logic [2:0]               n_data;
		logic                     has_end;
		logic [15:0]              end_count;
		logic                     end_err;
	} cmd_t;

	function automatic logic is_space_code(input logic [31:0] c);
		logic hit;
		hit = (c == {24'h0, CH_SPACE}) || (c == {24'h0, CH_TAB}) ||
			(c == {24'h0, CH_NUL}) || (c == {24'h0, CH_LF}) ||
			(c == {24'h0, CH_VT}) || (c == {24'h0, CH_CR}) ||
			(c == U_NBSP) || (c == U_OGHAM) || (c == U_NNBSP) ||
			(c == U_MMSP) || (c == U_IDEO) ||
			((c >= U_RANGE_LO) && (c <= U_RANGE_HI));
		return hit;
	endfunction

	function automatic logic is_pass_char(input logic [7:0] c);
		logic hit;
		hit = ((c >= CH_DIGIT_0) && (c <= CH_DIGIT_9)) ||
			((c >= CH_LOWER_A) && (c <= CH_LOWER_Z)) ||
			(c == CH_APOS) || (c == CH_COMMA) || (c == CH_AMP) ||
			(c == CH_HASH) || (c == CH_SEMI);
		return hit;
	endfunction

endpackage

@@ src/utn_front.sv @@
// Front end: decodes UTF-8, tracks record state and builds at most one request per byte.
`timescale 1ns / 1ps

module utn_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  utn_pkg::in_item_t in_item,
	input  logic             fifo_full,
	input  logic             cfg_wr_en,
	input  logic [15:0]      cfg_wr_data,
	output logic             cmd_valid,
	output utn_pkg::cmd_t    cmd
);

	logic [15:0]             limit_q;
	logic                    in_space_q, in_space_n;
	logic [23:0]             held_q, held_n;
	logic [1:0]              needed_q, needed_n;
	logic [2:0]              seq_len_q, seq_len_n;
	logic [utn_pkg::CNT_W-1:0] count_q, count_n;
	logic                    halted_q, halted_n;
	logic                    err_q, err_n;

	logic                    accept;
	logic [7:0]              b;
	logic                    char_valid;
	logic [31:0]             code;
	logic [3:0][7:0]         cbytes;
	logic [2:0]              clen;
	logic                    lead;
	logic                    fits;
	logic [2:0]              n_emit;
	logic [2:0]              j;
	logic [2:0]              k;
	logic [utn_pkg::CNT_W:0] reach;

	assign accept = push && !fifo_full;
	assign b      = in_item.in_byte;
	assign cbytes = code;

	always_comb begin
		in_space_n = in_space_q;
		held_n     = held_q;
		needed_n   = needed_q;
		seq_len_n  = seq_len_q;
		halted_n   = halted_q;
		err_n      = err_q;
		char_valid = 1'b0;
		code       = '0;
		clen       = 3'd1;
		lead       = 1'b0;
		fits       = 1'b0;
		n_emit     = 3'd0;
		j          = 3'd0;
		k          = 3'd0;
		reach      = '0;
		cmd        = '0;

		if (!halted_q) begin
			if (needed_q == 2'd0) begin
				priority if (count_q >= limit_q) begin
					halted_n = 1'b1;
				end else if (!b[7]) begin
					char_valid = 1'b1;
					code       = {24'h0, b};
					clen       = 3'd1;
				end else if (b[7:5] == 3'b110) begin
					held_n    = {16'h0, b};
					needed_n  = 2'd1;
					seq_len_n = 3'd2;
				end else if (b[7:4] == 4'b1110) begin
					held_n    = {16'h0, b};
					needed_n  = 2'd2;
					seq_len_n = 3'd3;
				end else if (b[7:3] == 5'b11110) begin
					held_n    = {16'h0, b};
					needed_n  = 2'd3;
					seq_len_n = 3'd4;
				end else begin
					err_n    = 1'b1;
					halted_n = 1'b1;
				end
			end else if (b[7:6] == 2'b10) begin
				if (needed_q == 2'd1) begin
					char_valid = 1'b1;
					code       = {held_q, b};
					clen       = seq_len_q;
					needed_n   = 2'd0;
					held_n     = '0;
					seq_len_n  = 3'd0;
				end else begin
					held_n   = {held_q[15:0], b};
					needed_n = needed_q - 2'd1;
				end
			end else begin
				err_n    = 1'b1;
				halted_n = 1'b1;
			end
		end

		if (char_valid) begin
			priority if (clen == 3'd1 && b >= utn_pkg::CH_UPPER_A &&
				b <= utn_pkg::CH_UPPER_Z) begin
				in_space_n  = 1'b0;
				cmd.data[0] = b + utn_pkg::CH_CASE_OFS;
				n_emit      = 3'd1;
			end else if (clen == 3'd1 && utn_pkg::is_pass_char(b)) begin
				in_space_n  = 1'b0;
				cmd.data[0] = b;
				n_emit      = 3'd1;
			end else if (utn_pkg::is_space_code(code)) begin
				if (!in_space_q) begin
					cmd.data[0] = utn_pkg::CH_SPACE;
					n_emit      = 3'd1;
					in_space_n  = 1'b1;
				end
			end else begin
				// Other character: optional leading space, then its bytes and a
				// trailing space, but only if the bytes fit under the limit.
				lead  = !in_space_q;
				reach = {1'b0, count_q} + (utn_pkg::CNT_W+1)'(lead) +
					(utn_pkg::CNT_W+1)'(clen);
				fits  = reach < {1'b0, limit_q};
				if (fits) begin
					n_emit     = 3'(lead) + clen + 3'd1;
					in_space_n = 1'b1;
				end else begin
					n_emit   = 3'(lead);
					halted_n = 1'b1;
				end
				for (int i = 0; i < utn_pkg::MAX_DATA; i++) begin
					j = 3'(i) - 3'(lead);
					k = clen - 3'd1 - j;
					if (lead && i == 0) begin
						cmd.data[i] = utn_pkg::CH_SPACE;
					end else if (j < clen) begin
						cmd.data[i] = cbytes[k[1:0]];
					end else if (j == clen) begin
						cmd.data[i] = utn_pkg::CH_SPACE;
					end
				end
			end
		end

		count_n    = count_q + utn_pkg::CNT_W'(n_emit);
		cmd.n_data = n_emit;

		if (in_item.last_byte) begin
			cmd.has_end   = 1'b1;
			cmd.end_count = 16'(count_n);
			cmd.end_err   = err_n || (!halted_n && needed_n != 2'd0);
			in_space_n = 1'b0;
			held_n     = '0;
			needed_n   = 2'd0;
			seq_len_n  = 3'd0;
			count_n    = '0;
			halted_n   = 1'b0;
			err_n      = 1'b0;
		end

		cmd_valid = accept && (n_emit != 3'd0 || in_item.last_byte);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q    <= utn_pkg::LIMIT_RESET;
			in_space_q <= 1'b0;
			held_q     <= '0;
			needed_q   <= 2'd0;
			seq_len_q  <= 3'd0;
			count_q    <= '0;
			halted_q   <= 1'b0;
			err_q      <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				limit_q <= cfg_wr_data;
			end
			if (accept) begin
				in_space_q <= in_space_n;
				held_q     <= held_n;
				needed_q   <= needed_n;
				seq_len_q  <= seq_len_n;
				count_q    <= count_n;
				halted_q   <= halted_n;
				err_q      <= err_n;
			end
		end
	end

	// Every request carries at least one result.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid |-> (cmd.n_data != 3'd0 || cmd.has_end))
		else $error("front issued an empty request");

	// The count never passes the limit in the middle of a record.
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !in_item.last_byte && $stable(limit_q)) |=>
			(count_q <= limit_q || $past(count_q) > $past(limit_q)))
		else $error("record count overran the output limit");

endmodule

@@ src/utn_cmd_fifo.sv @@
// Short request queue between the front end and the back end.
`timescale 1ns / 1ps

module utn_cmd_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  utn_pkg::cmd_t wr_data,
	input  logic          rd_en,
	output utn_pkg::cmd_t head,
	output logic          empty,
	output logic          full
);

	utn_pkg::cmd_t                 entry_q [utn_pkg::FIFO_DEPTH];
	logic [utn_pkg::FIFO_AW-1:0]   wr_ptr_q;
	logic [utn_pkg::FIFO_AW-1:0]   rd_ptr_q;
	logic [utn_pkg::FIFO_AW:0]     fill_q;

	assign empty = (fill_q == '0);
	assign full  = (fill_q == (utn_pkg::FIFO_AW+1)'(utn_pkg::FIFO_DEPTH));
	assign head  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			entry_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + utn_pkg::FIFO_AW'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + utn_pkg::FIFO_AW'(1);
			end
			unique case ({wr_en, rd_en})
				2'b10:   fill_q <= fill_q + (utn_pkg::FIFO_AW+1)'(1);
				2'b01:   fill_q <= fill_q - (utn_pkg::FIFO_AW+1)'(1);
				default: fill_q <= fill_q;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) wr_en |-> !full)
		else $error("request queue overflow");

	assert property (@(posedge clk) disable iff (!arst_n) rd_en |-> !empty)
		else $error("request queue underflow");

	// Pointers and fill level must stay consistent.
	assert property (@(posedge clk) disable iff (!arst_n)
		(wr_ptr_q - rd_ptr_q) == fill_q[utn_pkg::FIFO_AW-1:0])
		else $error("request queue pointers disagree with fill level");

endmodule

@@ src/utn_back.sv @@
// Back end: expands each queued request into its result items, one per cycle while the receiver pops.
`timescale 1ns / 1ps

module utn_back (
	input  logic               clk,
	input  logic               arst_n,
	input  utn_pkg::cmd_t      head,
	input  logic               fifo_empty,
	output logic               fifo_rd,
	input  logic               pop,
	output utn_pkg::out_item_t out_item
);

	logic [2:0] idx_q;
	logic [2:0] total;
	logic [2:0] sel;
	logic       is_end;
	logic       is_last;
	logic       take;

	assign total   = head.n_data + 3'(head.has_end);
	assign is_end  = (idx_q == head.n_data);
	assign is_last = (idx_q == total - 3'd1);
	assign take    = pop && !fifo_empty;
	assign fifo_rd = take && is_last;
	// The end marker slot lies past the data bytes; keep the index in range.
	assign sel     = (idx_q < 3'(utn_pkg::MAX_DATA)) ? idx_q : 3'd0;

	always_comb begin
		out_item             = '0;
		out_item.end_marker  = is_end;
		out_item.last_of_run = is_last;
		if (is_end) begin
			out_item.out_count = head.end_count;
			out_item.bad_input = head.end_err;
		end else begin
			out_item.out_byte = head.data[sel];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= 3'd0;
		end else if (take) begin
			idx_q <= is_last ? 3'd0 : idx_q + 3'd1;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		!fifo_empty |-> (idx_q < total))
		else $error("result index ran past the request");

endmodule

@@ src/utf8_token_normalizer_core.sv @@
// Usage notes:
// The block takes one raw UTF-8 byte per request on the input queue (push/full)
// with last_byte marking the end of a record, and gives normalized result
// items on the output queue (empty/pop), oldest first.
// Each input byte yields zero to seven results: data bytes, then for the last
// byte of a record an end marker carrying the byte count and the error flag.
// last_of_run is set on the final result caused by one input byte.
// The first result of a byte reaches the output through the request queue,
// behind any older requests. Input bytes are taken one per cycle while the
// four-entry request queue has room; results leave one per cycle while the
// receiver pops. The output side sets the rate.
// When the receiver stops popping, the queue fills and full rises; nothing
// is dropped. Reset clears the queue and the record state and sets the
// output limit to 1024; cfg_wr_en with cfg_wr_data sets it, between records.
`timescale 1ns / 1ps

module utf8_token_normalizer_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  utn_pkg::in_item_t  in_item,
	output logic               empty,
	input  logic               pop,
	output utn_pkg::out_item_t out_item,
	input  logic               cfg_wr_en,
	input  logic [15:0]        cfg_wr_data
);

	logic          cmd_valid;
	utn_pkg::cmd_t cmd;
	utn_pkg::cmd_t head;
	logic          fifo_rd;
	logic          fifo_empty;
	logic          fifo_full;

	utn_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.in_item     (in_item),
		.fifo_full   (fifo_full),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.cmd_valid   (cmd_valid),
		.cmd         (cmd)
	);

	utn_cmd_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cmd_valid),
		.wr_data (cmd),
		.rd_en   (fifo_rd),
		.head    (head),
		.empty   (fifo_empty),
		.full    (fifo_full)
	);

	utn_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.fifo_empty (fifo_empty),
		.fifo_rd    (fifo_rd),
		.pop        (pop),
		.out_item   (out_item)
	);

	assign full  = fifo_full;
	assign empty = fifo_empty;

endmodule

@@ sim/tb_utf8_token_normalizer_core.sv @@
// Self-checking testbench for the UTF-8 token normalizer core.
`timescale 1ns / 1ps

module tb_utf8_token_normalizer_core;

	localparam int DRAIN_CYCLES   = 8;
	localparam int TAIL_CYCLES    = 16;
	localparam int WATCHDOG_LIMIT = 2000;

	logic                clk         = 1'b0;
	logic                arst_n      = 1'b0;
	logic                push        = 1'b0;
	logic                full;
	utn_pkg::in_item_t   in_item     = '0;
	logic                empty;
	logic                pop         = 1'b0;
	utn_pkg::out_item_t  out_item;
	logic                cfg_wr_en   = 1'b0;
	logic [15:0]         cfg_wr_data = '0;

	// Predicted output items, oldest first.
	utn_pkg::out_item_t  normalized_q[$];
	logic [7:0]          run_bytes[$];
	logic [7:0]          char_bytes[$];

	// Predictor copy of the record state and the limit register.
	logic        rec_in_space = 1'b0;
	logic [23:0] rec_held     = '0;
	int          rec_need     = 0;
	int          rec_len      = 0;
	int          rec_count    = 0;
	logic        rec_halted   = 1'b0;
	logic        rec_error    = 1'b0;
	logic [15:0] cur_limit    = utn_pkg::LIMIT_RESET;

	int          mismatch_count = 0;
	int          idle_cycles    = 0;
	logic        no_stall       = 1'b0;

	utf8_token_normalizer_core i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.in_item     (in_item),
		.empty       (empty),
		.pop         (pop),
		.out_item    (out_item),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	always #10 clk = ~clk;

	function automatic logic blank_code(input logic [31:0] code);
		logic hit;
		case (code)
			{24'h0, utn_pkg::CH_SPACE}, {24'h0, utn_pkg::CH_TAB},
			{24'h0, utn_pkg::CH_NUL}, {24'h0, utn_pkg::CH_LF},
			{24'h0, utn_pkg::CH_VT}, {24'h0, utn_pkg::CH_CR},
			utn_pkg::U_NBSP, utn_pkg::U_OGHAM, utn_pkg::U_NNBSP,
			utn_pkg::U_MMSP, utn_pkg::U_IDEO: hit = 1'b1;
			default: hit = (code >= utn_pkg::U_RANGE_LO) && (code <= utn_pkg::U_RANGE_HI);
		endcase
		return hit;
	endfunction

	function automatic logic kept_ascii(input logic [7:0] c);
		logic hit;
		case (c)
			utn_pkg::CH_APOS, utn_pkg::CH_COMMA, utn_pkg::CH_AMP,
			utn_pkg::CH_HASH, utn_pkg::CH_SEMI: hit = 1'b1;
			default: hit = ((c >= utn_pkg::CH_DIGIT_0) && (c <= utn_pkg::CH_DIGIT_9)) ||
				((c >= utn_pkg::CH_LOWER_A) && (c <= utn_pkg::CH_LOWER_Z));
		endcase
		return hit;
	endfunction

	function automatic int idle_len();
		int r;
		if (no_stall)
			return 0;
		r = int'($urandom_range(0, 99));
		if (r < 60)
			return 0;
		if (r < 92)
			return int'($urandom_range(1, 3));
		return int'($urandom_range(8, 40));
	endfunction

	task automatic put_byte(input logic [7:0] v);
		run_bytes.push_back(v);
		rec_count++;
	endtask

	task automatic take_char(input logic [31:0] code, input int len);
		int i;
		if (len == 1 && code[7:0] >= utn_pkg::CH_UPPER_A &&
				code[7:0] <= utn_pkg::CH_UPPER_Z) begin
			rec_in_space = 1'b0;
			put_byte(code[7:0] + utn_pkg::CH_CASE_OFS);
		end else if (len == 1 && kept_ascii(code[7:0])) begin
			rec_in_space = 1'b0;
			put_byte(code[7:0]);
		end else if (blank_code(code)) begin
			if (!rec_in_space) begin
				put_byte(utn_pkg::CH_SPACE);
				rec_in_space = 1'b1;
			end
		end else begin
			if (!rec_in_space)
				put_byte(utn_pkg::CH_SPACE);
			// The leading space stays even when the character itself does not fit.
			if (rec_count + len >= int'(cur_limit)) begin
				rec_halted = 1'b1;
			end else begin
				for (i = len - 1; i >= 0; i--)
					put_byte(code[8*i +: 8]);
				put_byte(utn_pkg::CH_SPACE);
				rec_in_space = 1'b1;
			end
		end
	endtask

	task automatic normalize_byte(input utn_pkg::in_item_t it);
		logic [7:0]         b;
		logic [31:0]        code;
		int                 len;
		int                 i;
		logic [15:0]        end_count;
		logic               end_err;
		utn_pkg::out_item_t item;
		b = it.in_byte;
		end_count = '0;
		end_err = 1'b0;
		run_bytes.delete();
		if (!rec_halted) begin
			if (rec_need == 0) begin
				if (rec_count >= int'(cur_limit)) begin
					rec_halted = 1'b1;
				end else if (b[7] == 1'b0) begin
					take_char({24'h0, b}, 1);
				end else if (b[7:5] == 3'b110) begin
					rec_held = {16'h0, b};
					rec_need = 1;
					rec_len = 2;
				end else if (b[7:4] == 4'b1110) begin
					rec_held = {16'h0, b};
					rec_need = 2;
					rec_len = 3;
				end else if (b[7:3] == 5'b11110) begin
					rec_held = {16'h0, b};
					rec_need = 3;
					rec_len = 4;
				end else begin
					rec_error = 1'b1;
					rec_halted = 1'b1;
				end
			end else if (b[7:6] == 2'b10) begin
				if (rec_need == 1) begin
					code = {rec_held, b};
					len = rec_len;
					rec_need = 0;
					rec_held = '0;
					rec_len = 0;
					take_char(code, len);
				end else begin
					rec_held = {rec_held[15:0], b};
					rec_need--;
				end
			end else begin
				rec_error = 1'b1;
				rec_halted = 1'b1;
			end
		end
		if (it.last_byte) begin
			if (!rec_halted && rec_need != 0)
				rec_error = 1'b1;
			end_count = rec_count[15:0];
			end_err = rec_error;
			rec_in_space = 1'b0;
			rec_held = '0;
			rec_need = 0;
			rec_len = 0;
			rec_count = 0;
			rec_halted = 1'b0;
			rec_error = 1'b0;
		end
		for (i = 0; i < run_bytes.size(); i++) begin
			item = '0;
			item.out_byte = run_bytes[i];
			item.last_of_run = !it.last_byte && (i == run_bytes.size() - 1);
			normalized_q.push_back(item);
		end
		if (it.last_byte) begin
			item = '0;
			item.end_marker = 1'b1;
			item.out_count = end_count;
			item.bad_input = end_err;
			item.last_of_run = 1'b1;
			normalized_q.push_back(item);
		end
	endtask

	task automatic check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatch_count++;
		end
	endtask

	// Prediction, checking and the watchdog all sample the values from before the edge.
	always @(posedge clk) begin
		utn_pkg::out_item_t want;
		if (arst_n) begin
			if (cfg_wr_en)
				cur_limit = cfg_wr_data;
			if (push && !full)
				normalize_byte(in_item);
			if (pop && !empty) begin
				if (normalized_q.size() == 0) begin
					$error("unexpected result: out_byte %0h, end_marker %0b, out_count %0h",
						out_item.out_byte, out_item.end_marker, out_item.out_count);
					mismatch_count++;
				end else begin
					want = normalized_q.pop_front();
					check_field("out_byte", 16'(want.out_byte), 16'(out_item.out_byte));
					check_field("end_marker", 16'(want.end_marker),
						16'(out_item.end_marker));
					check_field("out_count", want.out_count, out_item.out_count);
					check_field("bad_input", 16'(want.bad_input), 16'(out_item.bad_input));
					check_field("last_of_run", 16'(want.last_of_run),
						16'(out_item.last_of_run));
				end
			end
		end
		if ((push && !full) || (pop && !empty))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Result side: bursts of pops broken by random stalls.
	initial begin
		int n;
		wait (arst_n);
		forever begin
			pop <= 1'b1;
			repeat ($urandom_range(1, 24)) @(posedge clk);
			n = idle_len();
			if (n > 0) begin
				pop <= 1'b0;
				repeat (n) @(posedge clk);
			end
		end
	end

	// Called at a rising edge; returns at the edge that accepts the request.
	task automatic send_byte(input logic [7:0] b, input logic lb);
		int gap;
		gap = idle_len();
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		in_item <= {b, lb};
		@(posedge clk);
		while (full)
			@(posedge clk);
	endtask

	task automatic wait_drained();
		push <= 1'b0;
		@(posedge clk);
		while (normalized_q.size() != 0)
			@(posedge clk);
		// A byte that gives no result may still be in flight.
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_limit(input logic [15:0] v);
		wait_drained();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic push_code(input logic [31:0] c, input int len);
		int i;
		for (i = len - 1; i >= 0; i--)
			char_bytes.push_back(c[8*i +: 8]);
	endtask

	// Fills char_bytes with one character of the class picked by cls (0 to 99).
	task automatic make_char(input int cls);
		logic [7:0]  bad;
		logic [31:0] c;
		int          pick;
		char_bytes.delete();
		pick = int'($urandom_range(0, 6));
		if (cls < 15) begin
			char_bytes.push_back(8'($urandom_range(32'(utn_pkg::CH_UPPER_A),
				32'(utn_pkg::CH_UPPER_Z))));
		end else if (cls < 30) begin
			char_bytes.push_back(8'($urandom_range(32'(utn_pkg::CH_LOWER_A),
				32'(utn_pkg::CH_LOWER_Z))));
		end else if (cls < 38) begin
			char_bytes.push_back(8'($urandom_range(32'(utn_pkg::CH_DIGIT_0),
				32'(utn_pkg::CH_DIGIT_9))));
		end else if (cls < 44) begin
			case (pick % 5)
				0: char_bytes.push_back(utn_pkg::CH_APOS);
				1: char_bytes.push_back(utn_pkg::CH_COMMA);
				2: char_bytes.push_back(utn_pkg::CH_AMP);
				3: char_bytes.push_back(utn_pkg::CH_HASH);
				default: char_bytes.push_back(utn_pkg::CH_SEMI);
			endcase
		end else if (cls < 54) begin
			case (pick % 6)
				0: char_bytes.push_back(utn_pkg::CH_SPACE);
				1: char_bytes.push_back(utn_pkg::CH_TAB);
				2: char_bytes.push_back(utn_pkg::CH_NUL);
				3: char_bytes.push_back(utn_pkg::CH_LF);
				4: char_bytes.push_back(utn_pkg::CH_VT);
				default: char_bytes.push_back(utn_pkg::CH_CR);
			endcase
		end else if (cls < 60) begin
			char_bytes.push_back(8'($urandom_range(0, 127)));
		end else if (cls < 68) begin
			case (pick)
				0: push_code(utn_pkg::U_NBSP, 2);
				1: push_code(utn_pkg::U_OGHAM, 3);
				2: push_code(utn_pkg::U_RANGE_LO + 32'($urandom_range(0, 11)), 3);
				3: push_code(utn_pkg::U_NNBSP, 3);
				4: push_code(utn_pkg::U_MMSP, 3);
				5: push_code(utn_pkg::U_IDEO, 3);
				// Just past the space range; this one is an ordinary character.
				default: push_code(utn_pkg::U_RANGE_HI + 32'd1, 3);
			endcase
		end else if (cls < 76) begin
			c = {16'h0, 3'b110, 5'($urandom), 2'b10, 6'($urandom)};
			push_code(c, 2);
		end else if (cls < 84) begin
			c = {8'h0, 4'b1110, 4'($urandom), 2'b10, 6'($urandom), 2'b10, 6'($urandom)};
			push_code(c, 3);
		end else if (cls < 88) begin
			c = {5'b11110, 3'($urandom), 2'b10, 6'($urandom), 2'b10, 6'($urandom),
				2'b10, 6'($urandom)};
			push_code(c, 4);
		end else if (cls < 92) begin
			char_bytes.push_back(8'($urandom));
		end else if (cls < 96) begin
			make_char(int'($urandom_range(68, 83)));
			bad = 8'($urandom);
			if (bad[7:6] == 2'b10)
				bad[6] = 1'b1;
			char_bytes[char_bytes.size() - 1] = bad;
		end else begin
			make_char(int'($urandom_range(68, 87)));
		end
	endtask

	task automatic random_record(inout int sent);
		int nchars;
		int k;
		int j;
		int cls;
		int upto;
		nchars = int'($urandom_range(1, 8));
		for (k = 0; k < nchars; k++) begin
			cls = int'($urandom_range(0, 99));
			make_char(cls);
			upto = char_bytes.size();
			// A truncated character ends the record early.
			if (cls >= 96)
				upto = int'($urandom_range(1, char_bytes.size() - 1));
			for (j = 0; j < upto; j++) begin
				send_byte(char_bytes[j], (cls >= 96 || k == nchars - 1) && j == upto - 1);
				sent++;
			end
			if (cls >= 96)
				break;
		end
	endtask

	task automatic random_phase(input int n_bytes);
		int sent;
		sent = 0;
		while (sent < n_bytes)
			random_record(sent);
	endtask

	task automatic test_char_classes();
		send_byte(8'h41, 1'b0);
		send_byte(8'h5A, 1'b0);
		send_byte(8'h30, 1'b0);
		send_byte(8'h3B, 1'b0);
		send_byte(8'h21, 1'b0);
		send_byte(8'h09, 1'b0);
		send_byte(8'hC2, 1'b0);
		send_byte(8'hA0, 1'b0);
		send_byte(8'hE2, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'h8B, 1'b0);
		send_byte(8'h7A, 1'b0);
		// A four-byte character after a letter gives the longest run of results.
		send_byte(8'hF0, 1'b0);
		send_byte(8'h9F, 1'b0);
		send_byte(8'h98, 1'b0);
		send_byte(8'h80, 1'b1);
	endtask

	task automatic test_utf8_errors();
		send_byte(8'hFF, 1'b0);
		send_byte(8'h41, 1'b1);
		send_byte(8'hE3, 1'b0);
		send_byte(8'h80, 1'b1);
		send_byte(8'hC3, 1'b0);
		send_byte(8'h41, 1'b1);
	endtask

	task automatic test_limits();
		write_limit(16'd0);
		send_byte(8'h41, 1'b1);
		// The euro sign does not fit after its leading space, so the record halts.
		write_limit(16'd3);
		send_byte(8'h41, 1'b0);
		send_byte(8'hE2, 1'b0);
		send_byte(8'h82, 1'b0);
		send_byte(8'hAC, 1'b0);
		send_byte(8'h42, 1'b1);
	endtask

	task automatic test_random_records();
		write_limit(16'hFFFF);
		random_phase(15);
		write_limit(16'($urandom_range(1, 14)));
		random_phase(15);
		write_limit(utn_pkg::LIMIT_RESET);
		no_stall = 1'b1;
		random_phase(15);
		no_stall = 1'b0;
		write_limit(16'($urandom_range(15, 200)));
		random_phase(15);
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_char_classes();
		test_utf8_errors();
		test_limits();
		test_random_records();
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && normalized_q.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
